### design/blca_pkg.sv
// Shared types, request codes and controller/datapath interface structs for the LCA unit.
package blca_pkg;

   localparam int NODE_W = 10;

   typedef logic [NODE_W-1:0] node_type;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam node_type NODE_COUNT_RESET = 10'd1023;

   // depth read address source
   typedef enum logic [1:0] {
      DSEL_U,
      DSEL_V,
      DSEL_RD
   } dep_sel_type;

   // table read node source
   typedef enum logic [1:0] {
      NSEL_U,
      NSEL_V,
      NSEL_I,
      NSEL_RD
   } node_sel_type;

   // table read level source
   typedef enum logic {
      LSEL_LV,
      LSEL_JM1
   } lvl_sel_type;

   // response data source
   typedef enum logic {
      RSEL_TBL,
      RSEL_U
   } rsp_sel_type;

   typedef struct packed {
      logic         capture;
      logic         load_wr;
      logic         clear_wr;
      logic         build_wr;
      logic         dep_rd;
      dep_sel_type  dep_sel;
      logic         tbl_rd;
      node_sel_type tbl_node;
      lvl_sel_type  tbl_lvl;
      logic         du_cap;
      logic         swap_cap;
      logic         u_from_tbl;
      logic         pu_cap;
      logic         pair_upd;
      logic         lv_init;
      logic         lv_dec;
      logic         ij_init;
      logic         ij_step;
      logic         rsp_load;
      rsp_sel_type  rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic lift_ok;
      logic lv_zero;
      logic uv_equal;
      logic build_none;
      logic build_last;
   } status_type;

endpackage

### design/binary_lifting_lca_unit.sv
// Top level of the binary-lifting lowest-common-ancestor unit.
//
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     req_type, req_node_a, req_node_b, req_node_depth
// rsp      out        rsp_valid / rsp_stall     rsp_common_ancestor
// csr      in         csr_wr_en                 csr_wr_data (node_count)
//
// A load writes node a's parent into level 0 of the ancestor table and its depth into the
// depth store; a build fills levels 1 to LIFT_LEVELS - 1 for nodes 1 to top, where top is
// node_count capped at MAX_NODES - 1. Builds and queries read through the one read port
// of the ancestor table.
// Reset: after reset a clearing pass zeroes MAX_NODES * LIFT_LEVELS table entries (and
// the depth store alongside), one a cycle, with req_stall high; csr writes are taken.
// Stalls: one transaction is worked on at a time; a finished response waits in its
// output register while the next request is accepted.
module binary_lifting_lca_unit #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  blca_pkg::node_type csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  blca_pkg::node_type req_node_a,
   input  blca_pkg::node_type req_node_b,
   input  blca_pkg::node_type req_node_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output blca_pkg::node_type rsp_common_ancestor
);

   import blca_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: owns the state machine and the response valid flag
   blca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: memories, query registers, build counters, node_count register
   blca_datapath #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .req_node_depth      (req_node_depth),
      .cmd                 (cmd),
      .status              (status),
      .rsp_common_ancestor (rsp_common_ancestor)
   );

   // never overwrite a response that is still waiting to be taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten while stalled");

   // at most one of capture and the memory write sources per cycle
   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.load_wr, cmd.build_wr, cmd.clear_wr}))
      else $error("conflicting capture or write commands");

   // hold requests off while the clearing pass runs
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> req_stall)
      else $error("request accepted during clearing pass");

   // a response is loaded only while a transaction is in progress, never while idle
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> req_stall)
      else $error("response loaded while idle");

endmodule

### design/blca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blca_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/blca_datapath.sv
// Datapath of the LCA unit: ancestor and depth memories, query registers, counters.
module blca_datapath #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  blca_pkg::node_type   csr_wr_data,
   input  blca_pkg::node_type   req_node_a,
   input  blca_pkg::node_type   req_node_b,
   input  blca_pkg::node_type   req_node_depth,
   input  blca_pkg::cmd_type    cmd,
   output blca_pkg::status_type status,
   output blca_pkg::node_type   rsp_common_ancestor
);

   import blca_pkg::*;

   localparam int AW        = $clog2(MAX_NODES);
   localparam int TBL_DEPTH = MAX_NODES * LIFT_LEVELS;
   localparam int TAW       = $clog2(TBL_DEPTH);
   localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int SUM_W     = ((NODE_W > LIFT_LEVELS) ? NODE_W : LIFT_LEVELS) + 1;
   localparam logic [LW-1:0]  LV_TOP  = LW'(LIFT_LEVELS - 1);
   localparam logic [TAW-1:0] CLR_TOP = TAW'(TBL_DEPTH - 1);

   function automatic logic in_range(input node_type n);
      in_range = (int'(n) < MAX_NODES);
   endfunction

   function automatic logic [TAW-1:0] tbl_addr(input node_type n, input logic [LW-1:0] lvl);
      tbl_addr = TAW'(lvl) * TAW'(MAX_NODES) + TAW'(n);
   endfunction

   node_type          node_count_ff, node_count_in;
   node_type          u_ff, u_in, v_ff, v_in;
   node_type          du_ff, du_in, dv_ff, dv_in;
   node_type          pu_ff, pu_in;
   node_type          i_ff, i_in;
   logic [LW-1:0]     j_ff, j_in, lv_ff, lv_in;
   logic [TAW-1:0]    clr_ff, clr_in;
   logic              tbl_oor_ff, tbl_oor_in, dep_oor_ff, dep_oor_in;
   node_type          rsp_data_ff, rsp_data_in;

   node_type          tbl_rdata, dep_rdata, tbl_m, dep_m;
   node_type          top_n, tbl_rnode, dep_rnode;
   logic [LW-1:0]     tbl_rlvl;
   logic              load_ok, pair_go;

   logic              tbl_we, dep_we;
   logic [TAW-1:0]    tbl_waddr;
   node_type          tbl_wdata, dep_wdata;
   logic [AW-1:0]     dep_waddr;

   // out-of-range nodes read as node 0: depth 0, no ancestors
   assign tbl_m = tbl_oor_ff ? '0 : tbl_rdata;
   assign dep_m = dep_oor_ff ? '0 : dep_rdata;

   assign top_n   = (int'(node_count_ff) >= MAX_NODES) ? NODE_W'(MAX_NODES - 1) : node_count_ff;
   assign load_ok = (u_ff != '0) && in_range(u_ff);
   assign pair_go = (pu_ff != '0) && (tbl_m != '0) && (pu_ff != tbl_m);

   always_comb begin
      case (cmd.tbl_node)
         NSEL_U:  tbl_rnode = u_ff;
         NSEL_V:  tbl_rnode = v_ff;
         NSEL_I:  tbl_rnode = i_ff;
         NSEL_RD: tbl_rnode = tbl_m;
         default: tbl_rnode = u_ff;
      endcase
      case (cmd.tbl_lvl)
         LSEL_LV:  tbl_rlvl = lv_ff;
         LSEL_JM1: tbl_rlvl = j_ff - LW'(1);
         default:  tbl_rlvl = lv_ff;
      endcase
      case (cmd.dep_sel)
         DSEL_U:  dep_rnode = u_ff;
         DSEL_V:  dep_rnode = v_ff;
         DSEL_RD: dep_rnode = tbl_m;
         default: dep_rnode = u_ff;
      endcase
   end

   // write ports: clear sweep, build level fill, node load
   always_comb begin
      tbl_we    = cmd.clear_wr | cmd.build_wr | (cmd.load_wr & load_ok);
      tbl_waddr = tbl_addr(u_ff, '0);
      tbl_wdata = v_ff;
      if (cmd.clear_wr) begin
         tbl_waddr = clr_ff;
         tbl_wdata = '0;
      end else if (cmd.build_wr) begin
         tbl_waddr = tbl_addr(i_ff, j_ff);
         tbl_wdata = tbl_m;
      end
      dep_we    = (cmd.clear_wr & (int'(clr_ff) < MAX_NODES)) | (cmd.load_wr & load_ok);
      dep_waddr = cmd.clear_wr ? AW'(clr_ff) : AW'(u_ff);
      dep_wdata = cmd.clear_wr ? '0 : du_ff;
   end

   always_comb begin
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      du_in         = du_ff;
      dv_in         = dv_ff;
      pu_in         = pu_ff;
      lv_in         = lv_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      clr_in        = clr_ff;
      tbl_oor_in    = tbl_oor_ff;
      dep_oor_in    = dep_oor_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         u_in  = req_node_a;
         v_in  = req_node_b;
         du_in = req_node_depth;
      end
      if (cmd.du_cap) begin
         du_in = dep_m;
      end
      if (cmd.swap_cap) begin
         // keep the deeper node in u
         if (du_ff < dep_m) begin
            u_in  = v_ff;
            v_in  = u_ff;
            du_in = dep_m;
            dv_in = du_ff;
         end else begin
            dv_in = dep_m;
         end
      end
      if (cmd.u_from_tbl) begin
         u_in = tbl_m;
      end
      if (cmd.pu_cap) begin
         pu_in = tbl_m;
      end
      if (cmd.pair_upd && pair_go) begin
         u_in = pu_ff;
         v_in = tbl_m;
      end
      if (cmd.lv_init) begin
         lv_in = LV_TOP;
      end else if (cmd.lv_dec) begin
         lv_in = lv_ff - LW'(1);
      end
      if (cmd.ij_init) begin
         i_in = NODE_W'(1);
         j_in = LW'(1);
      end else if (cmd.ij_step) begin
         if (i_ff == top_n) begin
            i_in = NODE_W'(1);
            j_in = j_ff + LW'(1);
         end else begin
            i_in = i_ff + NODE_W'(1);
         end
      end
      if (cmd.clear_wr) begin
         clr_in = clr_ff + TAW'(1);
      end
      if (cmd.tbl_rd) begin
         tbl_oor_in = !in_range(tbl_rnode);
      end
      if (cmd.dep_rd) begin
         dep_oor_in = !in_range(dep_rnode);
      end
      if (cmd.rsp_load) begin
         rsp_data_in = (cmd.rsp_sel == RSEL_U) ? u_ff : tbl_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         clr_ff        <= '0;
         lv_ff         <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
      end else begin
         node_count_ff <= node_count_in;
         clr_ff        <= clr_in;
         lv_ff         <= lv_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
      end
      u_ff        <= u_in;
      v_ff        <= v_in;
      du_ff       <= du_in;
      dv_ff       <= dv_in;
      pu_ff       <= pu_in;
      tbl_oor_ff  <= tbl_oor_in;
      dep_oor_ff  <= dep_oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   blca_ram #(
      .WIDTH (NODE_W),
      .DEPTH (TBL_DEPTH)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (cmd.tbl_rd),
      .raddr (tbl_addr(tbl_rnode, tbl_rlvl)),
      .rdata (tbl_rdata)
   );

   blca_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_dep_ram (
      .clock (clock),
      .we    (dep_we),
      .waddr (dep_waddr),
      .wdata (dep_wdata),
      .re    (cmd.dep_rd),
      .raddr (AW'(dep_rnode)),
      .rdata (dep_rdata)
   );

   always_comb begin
      status.clr_last   = (clr_ff == CLR_TOP);
      status.lift_ok    = SUM_W'(du_ff) >= (SUM_W'(dv_ff) + (SUM_W'(1) << lv_ff));
      status.lv_zero    = (lv_ff == '0);
      status.uv_equal   = (u_ff == v_ff);
      status.build_none = (top_n == '0) || (LIFT_LEVELS == 1);
      status.build_last = (i_ff == top_n) && (j_ff == LV_TOP);
   end

   assign rsp_common_ancestor = rsp_data_ff;

endmodule

### design/blca_ctrl.sv
// Controller of the LCA unit: sequences clear, load, build and query steps.
module blca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_type,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  blca_pkg::status_type status,
   output blca_pkg::cmd_type    cmd
);

   import blca_pkg::*;

   typedef enum logic [18:0] {
      S_CLR    = 19'h00001,
      S_IDLE   = 19'h00002,
      S_LOAD   = 19'h00004,
      S_QRDA   = 19'h00008,
      S_QRDB   = 19'h00010,
      S_QSWAP  = 19'h00020,
      S_LCHK   = 19'h00040,
      S_LANC   = 19'h00080,
      S_LDEP   = 19'h00100,
      S_EQ     = 19'h00200,
      S_PRD    = 19'h00400,
      S_PU     = 19'h00800,
      S_PV     = 19'h01000,
      S_FRD    = 19'h02000,
      S_FUSE   = 19'h04000,
      S_BSTART = 19'h08000,
      S_BRD1   = 19'h10000,
      S_BRD2   = 19'h20000,
      S_BWR    = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clear_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_LOAD:  state_in = S_LOAD;
                  REQ_BUILD: state_in = S_BSTART;
                  REQ_QUERY: state_in = S_QRDA;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_QRDA: begin
            cmd.dep_rd  = 1'b1;
            cmd.dep_sel = DSEL_U;
            state_in    = S_QRDB;
         end
         S_QRDB: begin
            cmd.du_cap  = 1'b1;
            cmd.dep_rd  = 1'b1;
            cmd.dep_sel = DSEL_V;
            state_in    = S_QSWAP;
         end
         S_QSWAP: begin
            cmd.swap_cap = 1'b1;
            cmd.lv_init  = 1'b1;
            state_in     = S_LCHK;
         end
         S_LCHK: begin
            if (status.lift_ok) begin
               cmd.tbl_rd   = 1'b1;
               cmd.tbl_node = NSEL_U;
               cmd.tbl_lvl  = LSEL_LV;
               state_in     = S_LANC;
            end else if (status.lv_zero) begin
               state_in = S_EQ;
            end else begin
               cmd.lv_dec = 1'b1;
            end
         end
         S_LANC: begin
            cmd.u_from_tbl = 1'b1;
            cmd.dep_rd     = 1'b1;
            cmd.dep_sel    = DSEL_RD;
            state_in       = S_LDEP;
         end
         S_LDEP: begin
            cmd.du_cap = 1'b1;
            if (status.lv_zero) begin
               state_in = S_EQ;
            end else begin
               cmd.lv_dec = 1'b1;
               state_in   = S_LCHK;
            end
         end
         S_EQ: begin
            if (status.uv_equal) begin
               if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = RSEL_U;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.lv_init = 1'b1;
               state_in    = S_PRD;
            end
         end
         S_PRD: begin
            cmd.tbl_rd   = 1'b1;
            cmd.tbl_node = NSEL_U;
            cmd.tbl_lvl  = LSEL_LV;
            state_in     = S_PU;
         end
         S_PU: begin
            cmd.pu_cap   = 1'b1;
            cmd.tbl_rd   = 1'b1;
            cmd.tbl_node = NSEL_V;
            cmd.tbl_lvl  = LSEL_LV;
            state_in     = S_PV;
         end
         S_PV: begin
            cmd.pair_upd = 1'b1;
            if (status.lv_zero) begin
               state_in = S_FRD;
            end else begin
               cmd.lv_dec = 1'b1;
               state_in   = S_PRD;
            end
         end
         S_FRD: begin
            cmd.tbl_rd   = 1'b1;
            cmd.tbl_node = NSEL_U;
            cmd.tbl_lvl  = LSEL_LV;
            state_in     = S_FUSE;
         end
         S_FUSE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSEL_TBL;
               state_in     = S_IDLE;
            end
         end
         S_BSTART: begin
            if (status.build_none) begin
               state_in = S_IDLE;
            end else begin
               cmd.ij_init = 1'b1;
               state_in    = S_BRD1;
            end
         end
         S_BRD1: begin
            cmd.tbl_rd   = 1'b1;
            cmd.tbl_node = NSEL_I;
            cmd.tbl_lvl  = LSEL_JM1;
            state_in     = S_BRD2;
         end
         S_BRD2: begin
            cmd.tbl_rd   = 1'b1;
            cmd.tbl_node = NSEL_RD;
            cmd.tbl_lvl  = LSEL_JM1;
            state_in     = S_BWR;
         end
         S_BWR: begin
            cmd.build_wr = 1'b1;
            cmd.ij_step  = 1'b1;
            state_in     = status.build_last ? S_IDLE : S_BRD1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
